FILE: src/ts2d_pkg.sv
// Shared types, constants and arithmetic helpers of the 2D transform stack.
package ts2d_pkg;

    localparam int TS_STACK_DEPTH  = 16;
    localparam int TS_CORDIC_STEPS = 16;

    localparam int TRANS_W = 24;
    localparam int ANG_W   = 16;
    localparam int SCALE_W = 24;
    localparam int IN_W    = 16;
    localparam int CW      = 34;   // CORDIC x, y, z
    localparam int CS_W    = 18;   // cosine and sine, Q2.16
    localparam int MA_W    = 24;
    localparam int MB_W    = 23;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int B_W     = 44;   // c*tx - s*ty
    localparam int BL_W    = 22;
    localparam int ACC_W   = 70;
    localparam int OUT_W   = 32;

    localparam logic signed [SCALE_W-1:0] ONE_Q12  = 24'sd4096;
    localparam logic signed [CS_W-1:0]    ONE_Q16  = 18'sd65536;
    localparam logic signed [CW-1:0]      GAIN_Q30 = 34'sd652032874;

    // actions
    localparam logic [2:0] ACT_PUSH_COPY = 3'd0;
    localparam logic [2:0] ACT_PUSH_CMB  = 3'd1;
    localparam logic [2:0] ACT_POP       = 3'd2;
    localparam logic [2:0] ACT_IDENTITY  = 3'd3;
    localparam logic [2:0] ACT_TRANSLATE = 3'd4;
    localparam logic [2:0] ACT_ROTATE    = 3'd5;
    localparam logic [2:0] ACT_SCALE     = 3'd6;
    localparam logic [2:0] ACT_READ      = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // datapath operations
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE = 5'd0;
    localparam logic [OP_W-1:0] OP_RD   = 5'd1;
    localparam logic [OP_W-1:0] OP_SX   = 5'd2;
    localparam logic [OP_W-1:0] OP_SY   = 5'd3;
    localparam logic [OP_W-1:0] OP_WR   = 5'd4;
    localparam logic [OP_W-1:0] OP_RD2  = 5'd5;
    localparam logic [OP_W-1:0] OP_LD   = 5'd6;
    localparam logic [OP_W-1:0] OP_CORD = 5'd7;
    localparam logic [OP_W-1:0] OP_FIN  = 5'd8;
    localparam logic [OP_W-1:0] OP_P0   = 5'd9;
    localparam logic [OP_W-1:0] OP_P1   = 5'd10;
    localparam logic [OP_W-1:0] OP_P2   = 5'd11;
    localparam logic [OP_W-1:0] OP_P3   = 5'd12;
    localparam logic [OP_W-1:0] OP_M00  = 5'd13;
    localparam logic [OP_W-1:0] OP_M01  = 5'd14;
    localparam logic [OP_W-1:0] OP_M10  = 5'd15;
    localparam logic [OP_W-1:0] OP_M11  = 5'd16;
    localparam logic [OP_W-1:0] OP_OXL  = 5'd17;
    localparam logic [OP_W-1:0] OP_OXH  = 5'd18;
    localparam logic [OP_W-1:0] OP_RNDX = 5'd19;
    localparam logic [OP_W-1:0] OP_OYL  = 5'd20;
    localparam logic [OP_W-1:0] OP_OYH  = 5'd21;
    localparam logic [OP_W-1:0] OP_RNDY = 5'd22;

    localparam int MSEQ_LEN = 14;
    localparam int MSEQ_W   = 4;

    typedef struct packed {
        logic signed [TRANS_W-1:0] tx;
        logic signed [TRANS_W-1:0] ty;
        logic [ANG_W-1:0]          ang;
        logic signed [SCALE_W-1:0] scx;
        logic signed [SCALE_W-1:0] scy;
    } level_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            capture;
        logic            out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic cordic_last;
    } dp_stat_t;

    localparam level_t IDENTITY_LEVEL = '{tx: '0, ty: '0, ang: '0,
                                          scx: ONE_Q12, scy: ONE_Q12};

    function automatic logic [OP_W-1:0] mseq_op(input logic [MSEQ_W-1:0] idx);
        logic [OP_W-1:0] op;
        begin
            case (idx)
                4'd0:    op = OP_P0;
                4'd1:    op = OP_P1;
                4'd2:    op = OP_P2;
                4'd3:    op = OP_P3;
                4'd4:    op = OP_M00;
                4'd5:    op = OP_M01;
                4'd6:    op = OP_M10;
                4'd7:    op = OP_M11;
                4'd8:    op = OP_OXL;
                4'd9:    op = OP_OXH;
                4'd10:   op = OP_RNDX;
                4'd11:   op = OP_OYL;
                4'd12:   op = OP_OYH;
                4'd13:   op = OP_RNDY;
                default: op = OP_NONE;
            endcase
            return op;
        end
    endfunction

    // arctangent of 2^-i in units of 2^32 per turn
    function automatic logic signed [CW-1:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:    v = 32'h20000000;
                5'd1:    v = 32'h12E4051E;
                5'd2:    v = 32'h09FB385B;
                5'd3:    v = 32'h051111D4;
                5'd4:    v = 32'h028B0D43;
                5'd5:    v = 32'h0145D7E1;
                5'd6:    v = 32'h00A2F61E;
                5'd7:    v = 32'h00517C55;
                5'd8:    v = 32'h0028BE53;
                5'd9:    v = 32'h00145F2F;
                5'd10:   v = 32'h000A2F98;
                5'd11:   v = 32'h000517CC;
                5'd12:   v = 32'h00028BE6;
                5'd13:   v = 32'h000145F3;
                5'd14:   v = 32'h0000A2FA;
                5'd15:   v = 32'h0000517D;
                5'd16:   v = 32'h000028BE;
                5'd17:   v = 32'h0000145F;
                5'd18:   v = 32'h00000A30;
                5'd19:   v = 32'h00000518;
                5'd20:   v = 32'h0000028C;
                5'd21:   v = 32'h00000146;
                5'd22:   v = 32'h000000A3;
                5'd23:   v = 32'h00000051;
                default: v = 32'h0;
            endcase
            return $signed({2'b00, v});
        end
    endfunction

    // round half up to Q16.16 from Q.28 and saturate to 32 bits
    function automatic logic signed [OUT_W-1:0] rnd_sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        begin
            r = (v + ACC_W'(2048)) >>> 12;
            if (r > $signed(ACC_W'(64'h7FFFFFFF)))
                return 32'sh7FFFFFFF;
            else if (r < -$signed(ACC_W'(64'h80000000)))
                return 32'sh80000000;
            else
                return r[OUT_W-1:0];
        end
    endfunction

    function automatic logic signed [SCALE_W-1:0] rnd_sat24(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] r;
        begin
            r = (p + PROD_W'(2048)) >>> 12;
            if (r > $signed(PROD_W'(24'h7FFFFF)))
                return 24'sh7FFFFF;
            else if (r < -$signed(PROD_W'(24'h800000)))
                return 24'sh800000;
            else
                return r[SCALE_W-1:0];
        end
    endfunction

    function automatic logic signed [TRANS_W-1:0] add_sat24(input logic signed [TRANS_W-1:0] a,
                                                            input logic signed [IN_W-1:0] b);
        logic signed [TRANS_W:0] s;
        begin
            s = {a[TRANS_W-1], a} + (TRANS_W+1)'(b);
            if (s[TRANS_W] != s[TRANS_W-1])
                return s[TRANS_W] ? 24'sh800000 : 24'sh7FFFFF;
            else
                return s[TRANS_W-1:0];
        end
    endfunction

endpackage

FILE: src/transform_stack_2d_unit.sv
// Top level of the 2D transform stack: sequencer plus datapath.
//
// Input channel: in_valid / in_stall carry one command (action, dx, dy,
// angle, scale_x, scale_y). A transfer takes place at a clock edge with
// in_valid high and in_stall low. Output channel: out_valid / out_stall
// carry one result per command (status, level_count, m00..m11, offset_x,
// offset_y), the affine matrix of the top level after the command.
// From input transfer to out_valid a command passes through a memory read,
// two scale products, the write-back, a second read, the CORDIC
// iterations (one per cycle on a shared rotator) and fourteen operations
// on one shared multiplier. One command is in flight at a time; in_stall
// stays high until the result moves into the output register, so a new
// command is taken only after the previous result has been loaded there.
// The output register holds a result while out_stall is high; the next
// command still runs and waits at its end if the register is still full.
// Reset empties the stack and clears out_valid; level memory is not
// cleared, an entry is always written before its value is used.
module transform_stack_2d_unit
#(
    parameter int STACK_DEPTH  = ts2d_pkg::TS_STACK_DEPTH,
    parameter int CORDIC_STEPS = ts2d_pkg::TS_CORDIC_STEPS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        action,
    input  logic signed [ts2d_pkg::IN_W-1:0]  dx,
    input  logic signed [ts2d_pkg::IN_W-1:0]  dy,
    input  logic [ts2d_pkg::ANG_W-1:0]        angle,
    input  logic signed [ts2d_pkg::IN_W-1:0]  scale_x,
    input  logic signed [ts2d_pkg::IN_W-1:0]  scale_y,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic [4:0]                        level_count,
    output logic signed [ts2d_pkg::OUT_W-1:0] m00,
    output logic signed [ts2d_pkg::OUT_W-1:0] m01,
    output logic signed [ts2d_pkg::OUT_W-1:0] m10,
    output logic signed [ts2d_pkg::OUT_W-1:0] m11,
    output logic signed [ts2d_pkg::OUT_W-1:0] offset_x,
    output logic signed [ts2d_pkg::OUT_W-1:0] offset_y
);
    import ts2d_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ts2d_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    ts2d_dp
    #(
        .STACK_DEPTH  (STACK_DEPTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (action),
        .dx          (dx),
        .dy          (dy),
        .angle       (angle),
        .scale_x     (scale_x),
        .scale_y     (scale_y),
        .status      (status),
        .level_count (level_count),
        .m00         (m00),
        .m01         (m01),
        .m10         (m10),
        .m11         (m11),
        .offset_x    (offset_x),
        .offset_y    (offset_y)
    );

endmodule

FILE: src/ts2d_ctrl.sv
// Sequencer of the transform stack: handshakes and datapath operation order.
module ts2d_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output ts2d_pkg::dp_cmd_t  cmd,
    input  ts2d_pkg::dp_stat_t stat
);
    import ts2d_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_SX   = 4'd2;
    localparam logic [3:0] S_SY   = 4'd3;
    localparam logic [3:0] S_SDRN = 4'd4;
    localparam logic [3:0] S_WR   = 4'd5;
    localparam logic [3:0] S_RD2  = 4'd6;
    localparam logic [3:0] S_LD   = 4'd7;
    localparam logic [3:0] S_CORD = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;
    localparam logic [3:0] S_MSEQ = 4'd10;
    localparam logic [3:0] S_DRN  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0]        state_reg, state_next;
    logic [MSEQ_W-1:0] mseq_reg, mseq_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept;
    logic              load_ok;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign load_ok  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next   = state_reg;
        mseq_next    = mseq_reg;
        cmd.op       = OP_NONE;
        cmd.capture  = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_RD:
            begin
                cmd.op     = OP_RD;
                state_next = S_SX;
            end
            S_SX:
            begin
                cmd.op     = OP_SX;
                state_next = S_SY;
            end
            S_SY:
            begin
                cmd.op     = OP_SY;
                state_next = S_SDRN;
            end
            S_SDRN:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.op     = OP_WR;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.op     = OP_RD2;
                state_next = S_LD;
            end
            S_LD:
            begin
                cmd.op     = OP_LD;
                state_next = S_CORD;
            end
            S_CORD:
            begin
                cmd.op = OP_CORD;
                if (stat.cordic_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.op     = OP_FIN;
                mseq_next  = '0;
                state_next = S_MSEQ;
            end
            S_MSEQ:
            begin
                cmd.op    = mseq_op(mseq_reg);
                mseq_next = mseq_reg + MSEQ_W'(1);
                if (mseq_reg == MSEQ_W'(MSEQ_LEN - 1))
                    state_next = S_DRN;
            end
            S_DRN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (load_ok)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mseq_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mseq_reg      <= mseq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("result register overwritten while stalled");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_RD))
        else $error("accepted transfer did not start the sequence");

endmodule

FILE: src/ts2d_dp.sv
// Datapath of the transform stack: level memory, CORDIC unit, shared multiplier.
module ts2d_dp
#(
    parameter int STACK_DEPTH  = ts2d_pkg::TS_STACK_DEPTH,
    parameter int CORDIC_STEPS = ts2d_pkg::TS_CORDIC_STEPS
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ts2d_pkg::dp_cmd_t                      cmd,
    output ts2d_pkg::dp_stat_t                     stat,
    input  logic [2:0]                             action,
    input  logic signed [ts2d_pkg::IN_W-1:0]       dx,
    input  logic signed [ts2d_pkg::IN_W-1:0]       dy,
    input  logic [ts2d_pkg::ANG_W-1:0]             angle,
    input  logic signed [ts2d_pkg::IN_W-1:0]       scale_x,
    input  logic signed [ts2d_pkg::IN_W-1:0]       scale_y,
    output logic [1:0]                             status,
    output logic [4:0]                             level_count,
    output logic signed [ts2d_pkg::OUT_W-1:0]      m00,
    output logic signed [ts2d_pkg::OUT_W-1:0]      m01,
    output logic signed [ts2d_pkg::OUT_W-1:0]      m10,
    output logic signed [ts2d_pkg::OUT_W-1:0]      m11,
    output logic signed [ts2d_pkg::OUT_W-1:0]      offset_x,
    output logic signed [ts2d_pkg::OUT_W-1:0]      offset_y
);
    import ts2d_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int CNT_W  = $clog2(CORDIC_STEPS);

    // captured item
    logic [2:0]              act_reg;
    logic signed [IN_W-1:0]  dx_reg, dy_reg, sx_reg, sy_reg;
    logic [ANG_W-1:0]        ang_reg;

    // stack
    level_t                  level_mem [STACK_DEPTH];
    level_t                  rd_reg;
    logic [LVL_W-1:0]        lvl_reg, lvl_next;
    logic [LVL_W-1:0]        lvl_m1;
    logic                    empty, full, is_push;
    level_t                  base, wr_level;
    logic                    we, re;
    logic [ADDR_W-1:0]       wa;
    logic [1:0]              status_reg, status_next;
    logic signed [SCALE_W-1:0] new_scx_reg, new_scy_reg;

    // working values of the top level
    logic signed [TRANS_W-1:0] w_tx_reg, w_ty_reg;
    logic signed [SCALE_W-1:0] w_scx_reg, w_scy_reg;
    logic                      empty_reg;

    // CORDIC
    logic signed [CW-1:0]    x_reg, y_reg, z_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    flip_reg;
    logic signed [CW-1:0]    xs, ys, at, rx, ry;
    logic [ANG_W-1:0]        ld_ang, red_ang, quad;
    logic signed [CS_W-1:0]  c_reg, s_reg;

    // multiplier
    logic signed [MA_W-1:0]   ma;
    logic signed [MB_W-1:0]   mb;
    logic signed [PROD_W-1:0] prod_reg;
    logic [OP_W-1:0]          op_reg;
    logic signed [ACC_W-1:0]  acc_reg, prod_ext;
    logic signed [B_W-1:0]    bx_reg, by_reg;
    logic signed [OUT_W-1:0]  r00_reg, r01_reg, r10_reg, r11_reg, rox_reg, roy_reg;

    // result register
    logic [1:0]               o_status_reg;
    logic [4:0]               o_count_reg;
    logic signed [OUT_W-1:0]  o00_reg, o01_reg, o10_reg, o11_reg, oox_reg, ooy_reg;

    assign lvl_m1  = lvl_reg - LVL_W'(1);
    assign empty   = (lvl_reg == '0);
    assign full    = (lvl_reg == LVL_W'(STACK_DEPTH));
    assign is_push = (act_reg == ACT_PUSH_COPY) || (act_reg == ACT_PUSH_CMB);
    assign base    = empty ? IDENTITY_LEVEL : rd_reg;

    assign stat.cordic_last = (cnt_reg == CNT_W'(CORDIC_STEPS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            dx_reg  <= dx;
            dy_reg  <= dy;
            ang_reg <= angle;
            sx_reg  <= scale_x;
            sy_reg  <= scale_y;
        end
    end

    // level update and write-back
    always_comb
    begin
        wr_level    = base;
        we          = 1'b0;
        wa          = empty ? '0 : lvl_m1[ADDR_W-1:0];
        lvl_next    = lvl_reg;
        status_next = ST_OK;
        case (act_reg)
            ACT_PUSH_COPY, ACT_PUSH_CMB:
            begin
                wa = lvl_reg[ADDR_W-1:0];
                if (act_reg == ACT_PUSH_CMB)
                begin
                    wr_level.tx  = add_sat24(base.tx, dx_reg);
                    wr_level.ty  = add_sat24(base.ty, dy_reg);
                    wr_level.ang = base.ang + ang_reg;
                    wr_level.scx = new_scx_reg;
                    wr_level.scy = new_scy_reg;
                end
                if (full)
                    status_next = ST_OVERFLOW;
                else
                begin
                    we       = 1'b1;
                    lvl_next = lvl_reg + LVL_W'(1);
                end
            end
            ACT_POP:
            begin
                if (empty)
                    status_next = ST_UNDERFLOW;
                else
                    lvl_next = lvl_m1;
            end
            ACT_IDENTITY, ACT_TRANSLATE, ACT_ROTATE, ACT_SCALE:
            begin
                we = 1'b1;
                if (empty)
                    lvl_next = LVL_W'(1);
                if (act_reg == ACT_IDENTITY)
                    wr_level = IDENTITY_LEVEL;
                else if (act_reg == ACT_TRANSLATE)
                begin
                    wr_level.tx = add_sat24(base.tx, dx_reg);
                    wr_level.ty = add_sat24(base.ty, dy_reg);
                end
                else if (act_reg == ACT_ROTATE)
                    wr_level.ang = base.ang + ang_reg;
                else
                begin
                    wr_level.scx = new_scx_reg;
                    wr_level.scy = new_scy_reg;
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
        if (cmd.op != OP_WR)
            we = 1'b0;
    end

    assign re = (cmd.op == OP_RD) || (cmd.op == OP_RD2);

    always_ff @(posedge clk)
    begin
        if (we)
            level_mem[wa] <= wr_level;
        if (re)
            rd_reg <= level_mem[lvl_m1[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg    <= '0;
            status_reg <= ST_OK;
        end
        else if (cmd.op == OP_WR)
        begin
            lvl_reg    <= lvl_next;
            status_reg <= status_next;
        end
    end

    // CORDIC: fold the angle into the half turn around zero, then iterate
    assign ld_ang  = empty ? '0 : rd_reg.ang;
    assign quad    = ld_ang + 16'h4000;
    assign red_ang = quad[ANG_W-1] ? (ld_ang ^ 16'h8000) : ld_ang;
    assign xs      = x_reg >>> cnt_reg;
    assign ys      = y_reg >>> cnt_reg;
    assign at      = atan_turn(5'(cnt_reg));
    assign rx      = (x_reg + CW'(8192)) >>> 14;
    assign ry      = (y_reg + CW'(8192)) >>> 14;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LD:
            begin
                empty_reg <= empty;
                w_tx_reg  <= empty ? '0 : rd_reg.tx;
                w_ty_reg  <= empty ? '0 : rd_reg.ty;
                w_scx_reg <= empty ? ONE_Q12 : rd_reg.scx;
                w_scy_reg <= empty ? ONE_Q12 : rd_reg.scy;
                flip_reg  <= quad[ANG_W-1];
                x_reg     <= GAIN_Q30;
                y_reg     <= '0;
                z_reg     <= {{(CW - 32){red_ang[ANG_W-1]}}, red_ang, 16'h0000};
                cnt_reg   <= '0;
            end
            OP_CORD:
            begin
                if (!z_reg[CW-1])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            OP_FIN:
            begin
                if (empty_reg)
                begin
                    c_reg <= ONE_Q16;
                    s_reg <= '0;
                end
                else if (flip_reg)
                begin
                    c_reg <= -rx[CS_W-1:0];
                    s_reg <= -ry[CS_W-1:0];
                end
                else
                begin
                    c_reg <= rx[CS_W-1:0];
                    s_reg <= ry[CS_W-1:0];
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    // multiplier operand select
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            OP_SX:   begin ma = base.scx;  mb = MB_W'(sx_reg);   end
            OP_SY:   begin ma = base.scy;  mb = MB_W'(sy_reg);   end
            OP_P0:   begin ma = w_tx_reg;  mb = MB_W'(c_reg);    end
            OP_P1:   begin ma = w_ty_reg;  mb = MB_W'(s_reg);    end
            OP_P2:   begin ma = w_tx_reg;  mb = MB_W'(s_reg);    end
            OP_P3:   begin ma = w_ty_reg;  mb = MB_W'(c_reg);    end
            OP_M00:  begin ma = w_scx_reg; mb = MB_W'(c_reg);    end
            OP_M01:  begin ma = w_scx_reg; mb = -MB_W'(s_reg);   end
            OP_M10:  begin ma = w_scy_reg; mb = MB_W'(s_reg);    end
            OP_M11:  begin ma = w_scy_reg; mb = MB_W'(c_reg);    end
            OP_OXL:  begin ma = w_scx_reg; mb = $signed({1'b0, bx_reg[BL_W-1:0]}); end
            OP_OXH:  begin ma = w_scx_reg; mb = MB_W'($signed(bx_reg[B_W-1:BL_W])); end
            OP_OYL:  begin ma = w_scy_reg; mb = $signed({1'b0, by_reg[BL_W-1:0]}); end
            OP_OYH:  begin ma = w_scy_reg; mb = MB_W'($signed(by_reg[B_W-1:BL_W])); end
            default: begin ma = '0;        mb = '0;              end
        endcase
    end

    assign prod_ext = ACC_W'(prod_reg);

    // product stage, then accumulate or round in the following cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_reg <= OP_NONE;
        else
            op_reg <= cmd.op;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
        case (op_reg)
            OP_SX:   new_scx_reg <= rnd_sat24(prod_reg);
            OP_SY:   new_scy_reg <= rnd_sat24(prod_reg);
            OP_P0:   acc_reg <= prod_ext;
            OP_P1:   bx_reg  <= B_W'(acc_reg - prod_ext);
            OP_P2:   acc_reg <= prod_ext;
            OP_P3:   by_reg  <= B_W'(acc_reg + prod_ext);
            OP_M00:  r00_reg <= rnd_sat32(prod_ext);
            OP_M01:  r01_reg <= rnd_sat32(prod_ext);
            OP_M10:  r10_reg <= rnd_sat32(prod_ext);
            OP_M11:  r11_reg <= rnd_sat32(prod_ext);
            OP_OXL:  acc_reg <= prod_ext;
            OP_OXH:  acc_reg <= acc_reg + (prod_ext <<< BL_W);
            OP_RNDX: rox_reg <= rnd_sat32(acc_reg);
            OP_OYL:  acc_reg <= prod_ext;
            OP_OYH:  acc_reg <= acc_reg + (prod_ext <<< BL_W);
            OP_RNDY: roy_reg <= rnd_sat32(acc_reg);
            default: acc_reg <= acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            o_status_reg <= status_reg;
            o_count_reg  <= 5'(lvl_reg);
            o00_reg      <= r00_reg;
            o01_reg      <= r01_reg;
            o10_reg      <= r10_reg;
            o11_reg      <= r11_reg;
            oox_reg      <= rox_reg;
            ooy_reg      <= roy_reg;
        end
    end

    assign status      = o_status_reg;
    assign level_count = o_count_reg;
    assign m00         = o00_reg;
    assign m01         = o01_reg;
    assign m10         = o10_reg;
    assign m11         = o11_reg;
    assign offset_x    = oox_reg;
    assign offset_y    = ooy_reg;

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg <= LVL_W'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_full_push_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_WR && is_push && full) |=> $stable(lvl_reg))
        else $error("push on a full stack changed the level");

endmodule

FILE: tb/transform_stack_2d_unit_tb.sv
// Self-checking testbench of the 2D transform stack: queued commands, predicted matrices.
module transform_stack_2d_unit_tb;
    import ts2d_pkg::*;

    typedef struct packed {
        logic [2:0]         act;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [15:0]        ang;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         st;
        logic [4:0]         cnt;
        logic signed [31:0] a00;
        logic signed [31:0] a01;
        logic signed [31:0] a10;
        logic signed [31:0] a11;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
    } mat_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [2:0] action;
    logic signed [15:0] dx, dy, scale_x, scale_y;
    logic [15:0] angle;
    logic out_valid;
    logic out_stall;
    logic [1:0] status;
    logic [4:0] level_count;
    logic signed [31:0] m00, m01, m10, m11, offset_x, offset_y;

    transform_stack_2d_unit u_top (.*);

    cmd_t pending_cmds[$];
    mat_t expected_mats[$];
    int   errors;
    int   idle_cycles;
    bit   stim_done;
    bit   calm;
    int   hold_mark;        // index in pending_cmds where the sender drains first
    int   sent_count;
    int   in_gap;
    int   out_gap;

    // golden stack
    longint g_tx[16], g_ty[16], g_sx[16], g_sy[16];
    int unsigned g_ang[16];
    int unsigned g_level;

    localparam longint GAIN = 652032874;

    function automatic longint fshr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint atan_tbl(int i);
        longint t[24] = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
            64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53,
            64'h00145F2F, 64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3,
            64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30,
            64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
        return t[i];
    endfunction

    function automatic longint mulq12(longint a, longint b);
        longint hi, lo;
        hi = fshr(b, 12);
        lo = b - hi * 4096;
        return a * hi + fshr(a * lo + 2048, 12);
    endfunction

    function automatic logic signed [31:0] sat32(longint v);
        return 32'(clampv(v, -64'sd2147483648, 64'sd2147483647));
    endfunction

    function automatic longint scale_prod(longint a, longint b);
        return clampv(fshr(a * b + 2048, 12), -8388608, 8388607);
    endfunction

    task automatic cordic_sincos(input int unsigned ang, output longint c, output longint s);
        int unsigned a;
        bit flip;
        longint z, x, y, nx;
        a = ang & 16'hFFFF;
        flip = ((a + 16384) & 16'hFFFF) >= 32768;
        if (flip)
            a = a ^ 16'h8000;
        z = longint'($signed(16'(a))) * 65536;
        x = GAIN;
        y = 0;
        for (int i = 0; i < TS_CORDIC_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - fshr(y, i);
                y = y + fshr(x, i);
                z -= atan_tbl(i);
            end
            else
            begin
                nx = x + fshr(y, i);
                y = y - fshr(x, i);
                z += atan_tbl(i);
            end
            x = nx;
        end
        x = fshr(x + 8192, 14);
        y = fshr(y + 8192, 14);
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endtask

    task automatic seed_identity(int k);
        g_tx[k] = 0; g_ty[k] = 0; g_ang[k] = 0; g_sx[k] = 4096; g_sy[k] = 4096;
    endtask

    task automatic predict_matrix(input cmd_t cm);
        mat_t r;
        int unsigned p, n, t;
        longint tx, ty, scx, scy, c, s;
        r.st = ST_OK;
        case (cm.act)
            ACT_PUSH_COPY, ACT_PUSH_CMB:
            begin
                if (g_level >= TS_STACK_DEPTH)
                    r.st = ST_OVERFLOW;
                else if (g_level == 0)
                begin
                    seed_identity(0);
                    if (cm.act == ACT_PUSH_CMB)
                    begin
                        g_tx[0] = cm.dx; g_ty[0] = cm.dy; g_ang[0] = cm.ang;
                        g_sx[0] = cm.sx; g_sy[0] = cm.sy;
                    end
                    g_level = 1;
                end
                else
                begin
                    p = g_level - 1;
                    n = g_level;
                    g_tx[n] = g_tx[p]; g_ty[n] = g_ty[p]; g_ang[n] = g_ang[p];
                    g_sx[n] = g_sx[p]; g_sy[n] = g_sy[p];
                    if (cm.act == ACT_PUSH_CMB)
                    begin
                        g_tx[n] = clampv(g_tx[p] + cm.dx, -8388608, 8388607);
                        g_ty[n] = clampv(g_ty[p] + cm.dy, -8388608, 8388607);
                        g_ang[n] = (g_ang[p] + cm.ang) & 16'hFFFF;
                        g_sx[n] = scale_prod(g_sx[p], cm.sx);
                        g_sy[n] = scale_prod(g_sy[p], cm.sy);
                    end
                    g_level = n + 1;
                end
            end
            ACT_POP:
            begin
                if (g_level == 0)
                    r.st = ST_UNDERFLOW;
                else
                    g_level--;
            end
            ACT_READ: ;
            default:
            begin
                if (g_level == 0)
                begin
                    seed_identity(0);
                    g_level = 1;
                end
                t = g_level - 1;
                case (cm.act)
                    ACT_IDENTITY: seed_identity(t);
                    ACT_TRANSLATE:
                    begin
                        g_tx[t] = clampv(g_tx[t] + cm.dx, -8388608, 8388607);
                        g_ty[t] = clampv(g_ty[t] + cm.dy, -8388608, 8388607);
                    end
                    ACT_ROTATE: g_ang[t] = (g_ang[t] + cm.ang) & 16'hFFFF;
                    default:
                    begin
                        g_sx[t] = scale_prod(g_sx[t], cm.sx);
                        g_sy[t] = scale_prod(g_sy[t], cm.sy);
                    end
                endcase
            end
        endcase
        if (g_level == 0)
        begin
            tx = 0; ty = 0; scx = 4096; scy = 4096; c = 65536; s = 0;
        end
        else
        begin
            t = g_level - 1;
            tx = g_tx[t]; ty = g_ty[t]; scx = g_sx[t]; scy = g_sy[t];
            cordic_sincos(g_ang[t], c, s);
        end
        r.cnt = 5'(g_level);
        r.a00 = sat32(mulq12(scx, c));
        r.a01 = sat32(mulq12(scx, -s));
        r.a10 = sat32(mulq12(scy, s));
        r.a11 = sat32(mulq12(scy, c));
        r.ox  = sat32(mulq12(scx, c * tx - s * ty));
        r.oy  = sat32(mulq12(scy, s * tx + c * ty));
        expected_mats.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic cmd_t mk(logic [2:0] a, int x, int y, int an, int sx, int sy);
        cmd_t cm;
        cm.act = a; cm.dx = 16'(x); cm.dy = 16'(y); cm.ang = 16'(an);
        cm.sx = 16'(sx); cm.sy = 16'(sy);
        return cm;
    endfunction

    function automatic cmd_t rand_cmd(int unsigned depth_hint);
        cmd_t cm;
        int unsigned r;
        cm.dx = 16'($urandom);
        cm.dy = 16'($urandom);
        cm.ang = 16'($urandom);
        cm.sx = 16'($urandom);
        cm.sy = 16'($urandom);
        // keep scales near unity mostly so products stay meaningful
        if ($urandom_range(0, 3) != 0)
        begin
            cm.sx = 16'($urandom_range(2048, 6144));
            cm.sy = $urandom_range(0, 1) ? cm.sx : 16'($urandom_range(2048, 6144));
            if ($urandom_range(0, 4) == 0)
                cm.sx = -cm.sx;
        end
        r = $urandom_range(0, 9);
        if (r < 3)
            cm.act = depth_hint > 12 ? ACT_POP : 3'($urandom_range(0, 1));
        else if (r == 3)
            cm.act = depth_hint < 3 ? ACT_PUSH_CMB : ACT_POP;
        else
            cm.act = 3'($urandom_range(0, 7));
        return cm;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        int unsigned depth;
        rst_n = 1'b0;
        errors = 0;
        stim_done = 1'b0;
        g_level = 0;
        // directed part: empty-stack cases, every action, extremes
        pending_cmds.push_back(mk(ACT_READ, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(ACT_POP, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(ACT_PUSH_COPY, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(ACT_POP, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(ACT_PUSH_CMB, 32767, -32768, 16384, 32767, -32768));
        pending_cmds.push_back(mk(ACT_PUSH_CMB, 32767, -32768, 65535, 32767, 32767));
        pending_cmds.push_back(mk(ACT_POP, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(ACT_POP, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(ACT_TRANSLATE, -32768, 32767, 0, 0, 0));
        for (int i = 0; i < 6; i++)
            pending_cmds.push_back(mk(ACT_TRANSLATE, 32767, -32768, 0, 0, 0));
        pending_cmds.push_back(mk(ACT_ROTATE, 0, 0, 32768, 0, 0));
        pending_cmds.push_back(mk(ACT_SCALE, 0, 0, 0, -32768, 32767));
        pending_cmds.push_back(mk(ACT_IDENTITY, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(ACT_POP, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(ACT_SCALE, 0, 0, 0, 8192, 4096));
        for (int i = 0; i < 17; i++)
            pending_cmds.push_back(mk(ACT_PUSH_COPY, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(ACT_PUSH_CMB, 1, 1, 1, 4096, 4096));
        hold_mark = pending_cmds.size();
        depth = 16;
        for (int i = 0; i < 850; i++)
        begin
            cmd_t cm;
            cm = rand_cmd(depth);
            if (cm.act <= ACT_PUSH_CMB && depth < 16)
                depth++;
            else if (cm.act == ACT_POP && depth > 0)
                depth--;
            else if (cm.act >= ACT_IDENTITY && cm.act <= ACT_SCALE && depth == 0)
                depth = 1;
            pending_cmds.push_back(cm);
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= '0; dx <= '0; dy <= '0; angle <= '0; scale_x <= '0; scale_y <= '0;
            sent_count <= 0;
            in_gap <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            logic xfer;
            xfer = in_valid;
            if (xfer)
                sent_count <= sent_count + 1;
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (pending_cmds.size() == 0)
            begin
                in_valid <= 1'b0;
                stim_done <= !xfer;
            end
            else if (sent_count + xfer == hold_mark && expected_mats.size() != 0)
                in_valid <= 1'b0;
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                in_valid <= 1'b0;
                in_gap <= $urandom_range(0, 3);
            end
            else
            begin
                cmd_t cm;
                cm = pending_cmds.pop_front();
                predict_matrix(cm);
                in_valid <= 1'b1;
                action <= cm.act; dx <= cm.dx; dy <= cm.dy; angle <= cm.ang;
                scale_x <= cm.sx; scale_y <= cm.sy;
            end
        end
    end

    assign calm = pending_cmds.size() < 100;

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                idle_cycles <= 0;
                if (expected_mats.size() == 0)
                begin
                    $display("unexpected result transfer");
                    errors++;
                end
                else
                begin
                    mat_t w;
                    w = expected_mats.pop_front();
                    if (status !== w.st) report_mismatch("status", status, w.st);
                    if (level_count !== w.cnt) report_mismatch("level_count", level_count, w.cnt);
                    if (m00 !== w.a00) report_mismatch("m00", m00, w.a00);
                    if (m01 !== w.a01) report_mismatch("m01", m01, w.a01);
                    if (m10 !== w.a10) report_mismatch("m10", m10, w.a10);
                    if (m11 !== w.a11) report_mismatch("m11", m11, w.a11);
                    if (offset_x !== w.ox) report_mismatch("offset_x", offset_x, w.ox);
                    if (offset_y !== w.oy) report_mismatch("offset_y", offset_y, w.oy);
                end
            end
            else if (in_valid && !in_stall)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_gap > 0)
            begin
                out_stall <= 1'b1;
                out_gap <= out_gap - 1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                out_gap <= $urandom_range(0, 3);
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        wait (rst_n);
        wait ((stim_done && expected_mats.size() == 0) || idle_cycles >= 2000);
        if (idle_cycles >= 2000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            repeat (60) @(posedge clk);
            if (errors == 0 && expected_mats.size() == 0)
                $display("CHECK OK");
            else
                $display("CHECK FAILED");
            $finish;
        end
    end
endmodule
